// File: hw/rtl/q2e_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the quaternion to Euler angle converter.
// Depends on nothing; every other file of the block uses it.
package q2e_pkg;

	// Number formats
	localparam int INPUT_FRAC_BITS = 14;
	localparam int ANGLE_FRAC_BITS = 13;
	localparam int QW      = 16;                 // quaternion field width
	localparam int PW      = 2 * QW;             // product width
	localparam int SW      = PW + 2;             // doubled sum width, signed
	localparam int MW      = SW - 1;             // magnitude width of a sum
	localparam int SFB     = 2 * INPUT_FRAC_BITS;
	localparam int PSH     = (SFB > 30) ? SFB - 30 : 0;
	localparam int PSW     = SFB - PSH;          // arcsine argument width, root steps
	localparam int RW      = 2 * PSW;            // radicand width
	localparam int N_ITER  = 30;                 // rotation steps
	localparam int NORM    = 30;                 // leading one of a normalized vector
	localparam int CW      = NORM + 1;           // normalized component width
	localparam int XW      = CW + 4;             // rotation datapath width
	localparam int ZW      = 34;                 // angle accumulator width
	localparam int POS_W   = $clog2(MW);
	localparam int ANG_W   = 16;
	localparam int PITCH_W = 15;
	localparam int RND_SH  = 30 - ANGLE_FRAC_BITS;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int BACK_DEPTH = 4 + PSW + N_ITER;

	// Lanes of the angle engine
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;
	localparam int N_LANES    = 3;

	// Angles at 2^30 scale
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [32:0] RND_HALF    = 33'd1 << (RND_SH - 1);
	localparam logic [32:0] HALF_RND    = {1'b0, HALF_PI_Q30} + RND_HALF;
	localparam logic [ANG_W-1:0] PITCH_LIM = HALF_RND[RND_SH +: ANG_W];

	typedef struct packed {
		logic signed [PW-1:0] wx;
		logic signed [PW-1:0] yz;
		logic signed [PW-1:0] xx;
		logic signed [PW-1:0] yy;
		logic signed [PW-1:0] zz;
		logic signed [PW-1:0] wz;
		logic signed [PW-1:0] xy;
		logic signed [PW-1:0] wy;
		logic signed [PW-1:0] zx;
	} prod_t;

	typedef struct packed {
		logic          yneg;
		logic          xneg;
		logic [MW-1:0] ay;
		logic [MW-1:0] ax;
	} vec_t;

	typedef struct packed {
		vec_t           roll;
		vec_t           yaw;
		logic           p_neg;
		logic           p_clamp;
		logic [PSW-1:0] p_s;
	} sum_t;

	typedef struct packed {
		logic yneg;
		logic xneg;
		logic zero;
	} flag_t;

	typedef struct packed {
		flag_t roll;
		flag_t pitch;
		flag_t yaw;
		logic  clamp;
	} side_t;

	// Arctangent of 2^-i at 2^30 scale, truncated
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'h3243F6A8;
			5'd1:  r = 30'h1DAC6705;
			5'd2:  r = 30'h0FADBAFC;
			5'd3:  r = 30'h07F56EA6;
			5'd4:  r = 30'h03FEAB76;
			5'd5:  r = 30'h01FFD55B;
			5'd6:  r = 30'h00FFFAAA;
			5'd7:  r = 30'h007FFF55;
			5'd8:  r = 30'h003FFFEA;
			5'd9:  r = 30'h001FFFFD;
			5'd10: r = 30'h000FFFFF;
			5'd11: r = 30'h0007FFFF;
			5'd12: r = 30'h0003FFFF;
			5'd13: r = 30'h0001FFFF;
			5'd14: r = 30'h0000FFFF;
			5'd15: r = 30'h00007FFF;
			5'd16: r = 30'h00003FFF;
			5'd17: r = 30'h00001FFF;
			5'd18: r = 30'h00000FFF;
			5'd19: r = 30'h000007FF;
			5'd20: r = 30'h000003FF;
			5'd21: r = 30'h000001FF;
			5'd22: r = 30'h000000FF;
			5'd23: r = 30'h0000007F;
			5'd24: r = 30'h0000003F;
			5'd25: r = 30'h0000001F;
			5'd26: r = 30'h0000000F;
			5'd27: r = 30'h00000007;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Position of the highest set bit, zero for an empty word
	function automatic logic [POS_W-1:0] msb_pos(input logic [MW-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < MW; i++) begin
			if (v[i]) p = POS_W'(i);
		end
		return p;
	endfunction

endpackage

// File: hw/rtl/q2e_quat_if.sv
`timescale 1ns / 1ps
// Input channel of the converter: one quaternion per transfer.
// Depends on q2e_pkg for the field width.
interface q2e_quat_if;
	logic                           valid;
	logic                           ready;
	logic signed [q2e_pkg::QW-1:0]  quat_w;
	logic signed [q2e_pkg::QW-1:0]  quat_x;
	logic signed [q2e_pkg::QW-1:0]  quat_y;
	logic signed [q2e_pkg::QW-1:0]  quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: hw/rtl/q2e_euler_if.sv
`timescale 1ns / 1ps
// Output channel of the converter: roll, pitch, yaw and the pitch clamp flag per transfer.
// Depends on q2e_pkg for the angle widths.
interface q2e_euler_if;
	logic                                valid;
	logic                                ready;
	logic signed [q2e_pkg::ANG_W-1:0]    roll_angle;
	logic signed [q2e_pkg::PITCH_W-1:0]  pitch_angle;
	logic signed [q2e_pkg::ANG_W-1:0]    yaw_angle;
	logic                                pitch_clamped;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		input ready);
	modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		output ready);
endinterface

// File: hw/rtl/q2e_front.sv
`timescale 1ns / 1ps
// Front end: accepts quaternions and forms the nine component products in one stage.
// Depends on q2e_pkg and q2e_quat_if.
module q2e_front (
	input  logic            clk,
	input  logic            arst_n,
	q2e_quat_if.sink        quat,
	output logic            out_valid,
	input  logic            out_ready,
	output q2e_pkg::prod_t  out_prod
);
	import q2e_pkg::*;

	logic  v_s1;
	prod_t prod_s1;
	logic  take;

	assign quat.ready = !v_s1 || out_ready;
	assign take       = quat.valid && quat.ready;
	assign out_valid  = v_s1;
	assign out_prod   = prod_s1;

	// Track the product stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (out_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// Multiply on each transfer
	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1.wx <= quat.quat_w * quat.quat_x;
			prod_s1.yz <= quat.quat_y * quat.quat_z;
			prod_s1.xx <= quat.quat_x * quat.quat_x;
			prod_s1.yy <= quat.quat_y * quat.quat_y;
			prod_s1.zz <= quat.quat_z * quat.quat_z;
			prod_s1.wz <= quat.quat_w * quat.quat_z;
			prod_s1.xy <= quat.quat_x * quat.quat_y;
			prod_s1.wy <= quat.quat_w * quat.quat_y;
			prod_s1.zx <= quat.quat_z * quat.quat_x;
		end
	end

endmodule

// File: hw/rtl/q2e_fifo.sv
`timescale 1ns / 1ps
// Short product queue between the front end and the angle engine.
// Depends on q2e_pkg for its depth and entry type.
module q2e_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  q2e_pkg::prod_t  wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output q2e_pkg::prod_t  rd_data
);
	import q2e_pkg::*;

	prod_t              ent_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	logic               pop;

	assign wr_ready = cnt_q != (FIFO_AW + 1)'(FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = ent_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= wr_data;
	end

endmodule

// File: hw/rtl/q2e_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, floor rounding.
// Depends on q2e_pkg for the radicand width and stage count.
module q2e_isqrt (
	input  logic                   clk,
	input  logic                   en,
	input  logic [q2e_pkg::RW-1:0] v,
	output logic [q2e_pkg::PSW-1:0] root
);
	import q2e_pkg::*;

	logic [RW-1:0] rem_s  [1:PSW];
	logic [RW-1:0] root_s [1:PSW];

	assign root = root_s[PSW][PSW-1:0];

	for (genvar k = 0; k < PSW; k++) begin : g_stage
		logic [RW-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [RW:0]   bitv;
		logic [RW:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in  = v;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		assign bitv  = (RW + 1)'(1) << (RW - 2 - 2 * k);
		assign trial = {1'b0, root_in} + bitv;

		// Subtract the trial value when it fits
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					rem_s[k+1]  <= rem_in - trial[RW-1:0];
					root_s[k+1] <= (root_in >> 1) + bitv[RW-1:0];
				end else begin
					rem_s[k+1]  <= rem_in;
					root_s[k+1] <= root_in >> 1;
				end
			end
		end
	end

endmodule

// File: hw/rtl/q2e_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring rotator: drives y toward zero and accumulates the angle at 2^30 scale.
// Depends on q2e_pkg for widths and the arctangent table.
module q2e_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic [q2e_pkg::CW-1:0]        x_in,
	input  logic [q2e_pkg::CW-1:0]        y_in,
	output logic signed [q2e_pkg::ZW-1:0] z_out
);
	import q2e_pkg::*;

	logic signed [XW-1:0] x_s [1:N_ITER];
	logic signed [XW-1:0] y_s [1:N_ITER];
	logic signed [ZW-1:0] z_s [1:N_ITER];

	assign z_out = z_s[N_ITER];

	for (genvar k = 0; k < N_ITER; k++) begin : g_step
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic signed [ZW-1:0] zi;
		logic signed [ZW-1:0] ang;

		if (k == 0) begin : g_first
			assign xi = {{(XW - CW){1'b0}}, x_in};
			assign yi = {{(XW - CW){1'b0}}, y_in};
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[k];
			assign yi = y_s[k];
			assign zi = z_s[k];
		end

		assign ang = {{(ZW - 30){1'b0}}, atan_q30(5'(k))};

		// Rotate clockwise while y is nonnegative
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					x_s[k+1] <= xi + (yi >>> k);
					y_s[k+1] <= yi - (xi >>> k);
					z_s[k+1] <= zi + ang;
				end else begin
					x_s[k+1] <= xi - (yi >>> k);
					y_s[k+1] <= yi + (xi >>> k);
					z_s[k+1] <= zi - ang;
				end
			end
		end
	end

endmodule

// File: hw/rtl/q2e_back.sv
`timescale 1ns / 1ps
// Angle engine: sums, arcsine radicand, square root, normalize, three rotators, rounding.
// Depends on q2e_pkg, q2e_isqrt, q2e_cordic and q2e_euler_if.
module q2e_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  q2e_pkg::prod_t  in_prod,
	q2e_euler_if.source     euler
);
	import q2e_pkg::*;

	localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << SFB);
	localparam logic [MW-1:0]        ONE_M = MW'(64'd1 << SFB);
	localparam logic [PSW:0]         ONE_P = (PSW + 1)'(1) << PSW;

	logic en;
	logic vld_q [0:BACK_DEPTH-1];

	sum_t          sum_s1;
	sum_t          sum_s2;
	logic [RW-1:0] rad_s2;
	sum_t          sqd_s [0:PSW-1];
	logic [PSW-1:0] root;

	logic [MW-1:0]    ax_s3  [0:N_LANES-1];
	logic [MW-1:0]    ay_s3  [0:N_LANES-1];
	logic [POS_W-1:0] pos_s3 [0:N_LANES-1];
	side_t            side_s3;
	logic [CW-1:0]    x_s4   [0:N_LANES-1];
	logic [CW-1:0]    y_s4   [0:N_LANES-1];
	side_t            side_s4;
	side_t            csd_s  [0:N_ITER-1];
	logic signed [ZW-1:0] z_out [0:N_LANES-1];

	logic                 out_v_q;
	logic [ANG_W-1:0]     roll_q;
	logic [PITCH_W-1:0]   pitch_q;
	logic [ANG_W-1:0]     yaw_q;
	logic                 clamp_q;

	function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] a);
		return {{(SW - PW){a[PW-1]}}, a};
	endfunction

	function automatic logic [MW-1:0] absv(input logic signed [SW-1:0] a);
		logic [SW-1:0] u;
		u = a[SW-1] ? -a : a;
		return u[MW-1:0];
	endfunction

	function automatic vec_t mkvec(input logic signed [SW-1:0] y, input logic signed [SW-1:0] x);
		vec_t r;
		r.yneg = y[SW-1];
		r.xneg = x[SW-1];
		r.ay   = absv(y);
		r.ax   = absv(x);
		return r;
	endfunction

	function automatic logic [CW-1:0] norm(input logic [MW-1:0] a, input logic [POS_W-1:0] p);
		logic [63:0] e;
		e = {{(64 - MW){1'b0}}, a};
		if (p > POS_W'(NORM)) e = e >> (p - POS_W'(NORM));
		else                  e = e << (POS_W'(NORM) - p);
		return e[CW-1:0];
	endfunction

	// Clamp, unfold to the half plane, round and apply the sign
	function automatic logic [ANG_W-1:0] finish(input logic signed [ZW-1:0] z, input flag_t f);
		logic [31:0]      t;
		logic [32:0]      rs;
		logic [ANG_W-1:0] mag;
		if (f.zero || z < 0)                           t = '0;
		else if (z > $signed({2'b00, HALF_PI_Q30}))    t = HALF_PI_Q30;
		else                                           t = z[31:0];
		if (f.xneg) t = PI_Q30 - t;
		rs  = {1'b0, t} + RND_HALF;
		mag = rs[RND_SH +: ANG_W];
		return f.yneg ? -mag : mag;
	endfunction

	assign en       = !out_v_q || euler.ready;
	assign in_ready = en;

	// Shift the valid marks along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BACK_DEPTH; i++) vld_q[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < BACK_DEPTH; i++) vld_q[i] <= vld_q[i-1];
			out_v_q <= vld_q[BACK_DEPTH-1];
		end
	end

	// Form the arctangent operands and the arcsine argument
	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sp;
		logic [MW-1:0]        pm;
		if (en) begin
			sum_s1.roll <= mkvec((sx(in_prod.wx) + sx(in_prod.yz)) <<< 1,
				ONE_S - ((sx(in_prod.xx) + sx(in_prod.yy)) <<< 1));
			sum_s1.yaw  <= mkvec((sx(in_prod.wz) + sx(in_prod.xy)) <<< 1,
				ONE_S - ((sx(in_prod.yy) + sx(in_prod.zz)) <<< 1));
			sp = (sx(in_prod.wy) - sx(in_prod.zx)) <<< 1;
			pm = absv(sp);
			sum_s1.p_neg   <= sp[SW-1];
			sum_s1.p_clamp <= pm >= ONE_M;
			sum_s1.p_s     <= pm[PSH +: PSW];
		end
	end

	// Build the radicand (1 - s)(1 + s)
	always_ff @(posedge clk) begin
		logic [2*PSW+1:0] full;
		if (en) begin
			full   = (ONE_P - {1'b0, sum_s1.p_s}) * (ONE_P + {1'b0, sum_s1.p_s});
			rad_s2 <= full[RW-1:0];
			sum_s2 <= sum_s1;
		end
	end

	q2e_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.v    (rad_s2),
		.root (root)
	);

	// Hold the operands beside the square root
	always_ff @(posedge clk) begin
		if (en) begin
			sqd_s[0] <= sum_s2;
			for (int i = 1; i < PSW; i++) sqd_s[i] <= sqd_s[i-1];
		end
	end

	// Find the leading one of each vector
	always_ff @(posedge clk) begin
		logic [MW-1:0] ax [0:N_LANES-1];
		logic [MW-1:0] ay [0:N_LANES-1];
		logic [MW-1:0] m;
		logic          zr [0:N_LANES-1];
		if (en) begin
			ax[LANE_ROLL]  = sqd_s[PSW-1].roll.ax;
			ay[LANE_ROLL]  = sqd_s[PSW-1].roll.ay;
			ax[LANE_YAW]   = sqd_s[PSW-1].yaw.ax;
			ay[LANE_YAW]   = sqd_s[PSW-1].yaw.ay;
			ax[LANE_PITCH] = {{(MW - PSW){1'b0}}, root};
			ay[LANE_PITCH] = {{(MW - PSW){1'b0}}, sqd_s[PSW-1].p_s};
			for (int l = 0; l < N_LANES; l++) begin
				m = (ax[l] > ay[l]) ? ax[l] : ay[l];
				zr[l]     = m == '0;
				ax_s3[l]  <= ax[l];
				ay_s3[l]  <= ay[l];
				pos_s3[l] <= msb_pos(m);
			end
			side_s3.roll.yneg  <= sqd_s[PSW-1].roll.yneg;
			side_s3.roll.xneg  <= sqd_s[PSW-1].roll.xneg;
			side_s3.roll.zero  <= zr[LANE_ROLL];
			side_s3.yaw.yneg   <= sqd_s[PSW-1].yaw.yneg;
			side_s3.yaw.xneg   <= sqd_s[PSW-1].yaw.xneg;
			side_s3.yaw.zero   <= zr[LANE_YAW];
			side_s3.pitch.yneg <= sqd_s[PSW-1].p_neg;
			side_s3.pitch.xneg <= 1'b0;
			side_s3.pitch.zero <= zr[LANE_PITCH];
			side_s3.clamp      <= sqd_s[PSW-1].p_clamp;
		end
	end

	// Scale each vector so its larger part sits just below 2^31
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < N_LANES; l++) begin
				x_s4[l] <= norm(ax_s3[l], pos_s3[l]);
				y_s4[l] <= norm(ay_s3[l], pos_s3[l]);
			end
			side_s4 <= side_s3;
		end
	end

	for (genvar l = 0; l < N_LANES; l++) begin : g_lane
		q2e_cordic u_cordic (
			.clk   (clk),
			.en    (en),
			.x_in  (x_s4[l]),
			.y_in  (y_s4[l]),
			.z_out (z_out[l])
		);
	end

	// Hold the flags beside the rotators
	always_ff @(posedge clk) begin
		if (en) begin
			csd_s[0] <= side_s4;
			for (int i = 1; i < N_ITER; i++) csd_s[i] <= csd_s[i-1];
		end
	end

	// Round into the output register
	always_ff @(posedge clk) begin
		logic [ANG_W-1:0] pv;
		logic [ANG_W-1:0] pl;
		if (en) begin
			roll_q  <= finish(z_out[LANE_ROLL], csd_s[N_ITER-1].roll);
			yaw_q   <= finish(z_out[LANE_YAW], csd_s[N_ITER-1].yaw);
			pv      = finish(z_out[LANE_PITCH], csd_s[N_ITER-1].pitch);
			pl      = csd_s[N_ITER-1].pitch.yneg ? -PITCH_LIM : PITCH_LIM;
			pitch_q <= csd_s[N_ITER-1].clamp ? pl[PITCH_W-1:0] : pv[PITCH_W-1:0];
			clamp_q <= csd_s[N_ITER-1].clamp;
		end
	end

	assign euler.valid         = out_v_q;
	assign euler.roll_angle    = roll_q;
	assign euler.pitch_angle   = pitch_q;
	assign euler.yaw_angle     = yaw_q;
	assign euler.pitch_clamped = clamp_q;

endmodule

// File: hw/rtl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Quaternion to roll / pitch / yaw converter, top level.
// Channel quat (sink) carries quat_w, quat_x, quat_y, quat_z as signed Q1.14.
// Channel euler (source) carries roll_angle and yaw_angle as signed Q2.13 radians,
// pitch_angle as signed Q1.13 radians and pitch_clamped, set when the arcsine argument
// reached magnitude one. Every transfer on quat yields exactly one transfer on euler, in order.
// Throughput: one quaternion per cycle while the receiver takes results. The path
// from input transfer to output valid runs through the product stage, the queue and
// the angle engine, whose depth is set by the 28-step square root pipeline and the
// 30-step rotation pipelines.
// The front end multiplies and feeds a two-entry queue; the angle engine advances
// whenever its output register is empty or being taken, so a stalled receiver
// freezes the engine while the front end keeps accepting until the queue is full.
// Reset (arst_n low) empties every stage and the queue; no result is lost or
// repeated across a stall.
// Depends on q2e_pkg, the channel interfaces, q2e_front, q2e_fifo and q2e_back.
module quaternion_to_euler_angles (
	input  logic         clk,
	input  logic         arst_n,
	q2e_quat_if.sink     quat,
	q2e_euler_if.source  euler
);
	import q2e_pkg::*;

	logic  f_valid;
	logic  f_ready;
	prod_t f_prod;
	logic  q_valid;
	logic  q_ready;
	prod_t q_prod;

	q2e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_prod  (f_prod)
	);

	q2e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_prod),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_prod)
	);

	q2e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_prod  (q_prod),
		.euler    (euler)
	);

endmodule

// File: verif/tb_q2e_channels.sv
`timescale 1ns / 1ps
// Expected-result type shared by the converter testbench.
// Depends on q2e_pkg.
package tb_q2e_types;
	import q2e_pkg::*;

	typedef struct packed {
		logic signed [ANG_W-1:0]   roll;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [ANG_W-1:0]   yaw;
		logic                      clamp;
	} euler_t;
endpackage

// File: verif/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Testbench of the quaternion to Euler angle converter: a directed table and random
// quaternions are checked against fixed angles or a bit-exact CORDIC predictor.
// Depends on q2e_pkg, the channel interfaces, tb_q2e_types and the converter RTL.
module tb_quaternion_to_euler_angles;
	import q2e_pkg::*;
	import tb_q2e_types::*;

	localparam int N_RANDOM   = 1400;
	localparam int LIMIT      = 400000;
	localparam longint ONE_Q28 = 64'sd1 << (2 * INPUT_FRAC_BITS);

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 known;
		euler_t             res;
	} row_t;

	logic clk;
	logic arst_n;
	q2e_quat_if  quat();
	q2e_euler_if euler();

	quaternion_to_euler_angles uut (.clk(clk), .arst_n(arst_n), .quat(quat), .euler(euler));

	euler_t      angles_due[$];
	int          mismatches;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          recv_hold;
	row_t        table_rows[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Arithmetic shift with floor on a 64-bit value
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Angle of a first-quadrant vector at 2^30 scale
	function automatic longint quadrant_angle(longint ay, longint ax);
		longint m, x, y, z, nx;
		z = 0;
		m = (ax > ay) ? ax : ay;
		if (m == 0) return 0;
		while (m >= (64'sd1 << 31)) begin
			ax = ax >> 1; ay = ay >> 1; m = m >> 1;
		end
		while (m < (64'sd1 << 30)) begin
			ax = ax << 1; ay = ay << 1; m = m << 1;
		end
		x = ax;
		y = ay;
		for (int i = 0; i < N_ITER; i++) begin
			if (y >= 0) begin
				nx = x + floor_shift(y, i);
				y  = y - floor_shift(x, i);
				z  = z + longint'(atan_q30(5'(i)));
			end else begin
				nx = x - floor_shift(y, i);
				y  = y + floor_shift(x, i);
				z  = z - longint'(atan_q30(5'(i)));
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
		return z;
	endfunction

	function automatic longint round_angle(longint mag);
		return (mag + (64'sd1 << (RND_SH - 1))) >> RND_SH;
	endfunction

	function automatic logic [15:0] four_quadrant(longint y, longint x);
		longint t, r;
		t = quadrant_angle(y < 0 ? -y : y, x < 0 ? -x : x);
		if (x < 0) t = longint'(PI_Q30) - t;
		r = round_angle(t);
		if (y < 0) r = -r;
		return r[15:0];
	endfunction

	function automatic euler_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz);
		longint w, x, y, z, s, mag, s1, o1, c, p;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		e.roll = four_quadrant(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y));
		e.yaw  = four_quadrant(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z));
		s   = 2 * (w * y - z * x);
		mag = (s < 0) ? -s : s;
		if (mag >= ONE_Q28) begin
			p = round_angle(longint'(HALF_PI_Q30));
			e.clamp = 1'b1;
		end else begin
			s1 = mag >> PSH;
			o1 = ONE_Q28 >> PSH;
			c  = int_sqrt((o1 - s1) * (o1 + s1));
			p  = round_angle(quadrant_angle(s1, c));
			e.clamp = 1'b0;
		end
		if (s < 0) p = -p;
		e.pitch = p[PITCH_W-1:0];
		return e;
	endfunction

	function automatic euler_t typed(int r, int p, int y, bit c);
		euler_t e;
		e.roll = 16'(r); e.pitch = 15'(p); e.yaw = 16'(y); e.clamp = c;
		return e;
	endfunction

	function automatic row_t mk(int w, int x, int y, int z, bit known = 0,
			euler_t res = '0);
		row_t r;
		r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
		r.known = known;
		r.res = res;
		return r;
	endfunction

	// Offer one quaternion, record its expected angles on transfer, then possibly idle
	task automatic send_quat(logic signed [15:0] w, x, y, z, bit known, euler_t res);
		int gap;
		quat.valid  <= 1'b1;
		quat.quat_w <= w; quat.quat_x <= x; quat.quat_y <= y; quat.quat_z <= z;
		@(posedge clk);
		while (!quat.ready) @(posedge clk);
		angles_due.push_back(known ? res : euler_of(w, x, y, z));
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap == 0 && send_idle_pct == 0 && $urandom_range(7) == 0) gap = 1;
		if (gap > 0) begin
			quat.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rnd_comp(int mode);
		case (mode)
			0: return 16'($urandom_range(32768) - 16384);
			1: return 16'($urandom);
			default: return 16'($urandom_range(600) - 300);
		endcase
	endfunction

	// Random quaternion; mostly near unit norm
	task automatic send_random();
		real a, b, c, d, n;
		int sel;
		sel = $urandom_range(9);
		if (sel < 7) begin
			a = $itor($urandom_range(20000)) - 10000.0;
			b = $itor($urandom_range(20000)) - 10000.0;
			c = $itor($urandom_range(20000)) - 10000.0;
			d = $itor($urandom_range(20000)) - 10000.0;
			if ($urandom_range(3) == 0) c = c / 400.0 + ((sel & 1) ? 9000.0 : -9000.0);
			n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
			send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
				16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)), 0, '0);
		end else begin
			send_quat(rnd_comp(sel - 7), rnd_comp(sel - 7), rnd_comp(sel - 7),
				rnd_comp(sel - 7), 0, '0);
		end
	endtask

	task automatic drain_wait();
		while (angles_due.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler.ready <= 1'b0;
		end else begin
			euler.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each output transfer against the oldest expectation
	always @(posedge clk) begin
		euler_t want;
		if (arst_n && euler.valid && euler.ready) begin
			if (angles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer roll=%0d pitch=%0d yaw=%0d",
					euler.roll_angle, euler.pitch_angle, euler.yaw_angle);
			end else begin
				want = angles_due.pop_front();
				if (euler.roll_angle !== want.roll || euler.pitch_angle !== want.pitch ||
						euler.yaw_angle !== want.yaw || euler.pitch_clamped !== want.clamp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp r/p/y/c=%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.roll, want.pitch, want.yaw, want.clamp, euler.roll_angle,
							euler.pitch_angle, euler.yaw_angle, euler.pitch_clamped);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Long receiver hold, counted here while the sender keeps offering
	task automatic hold_receiver(int cycles);
		recv_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		recv_hold = 1'b0;
	endtask

	initial begin
		int p, q;
		cycle_count   = 0;
		mismatches    = 0;
		recv_hold     = 1'b0;
		send_idle_pct = 36;
		recv_idle_pct = 73;
		arst_n        = 1'b0;
		quat.valid    = 1'b0;
		quat.quat_w   = '0; quat.quat_x = '0; quat.quat_y = '0; quat.quat_z = '0;
		p = 12868;  // round(pi/2) at Q2.13
		q = 25736;  // round(pi)
		// identity, zero vector, axis rotations, clamp, extremes
		table_rows.push_back(mk(16384, 0, 0, 0, 1, typed(0, 0, 0, 0)));
		table_rows.push_back(mk(0, 0, 0, 0, 1, typed(0, 0, 0, 0)));
		table_rows.push_back(mk(0, 16384, 0, 0, 1, typed(q, 0, 0, 0)));
		table_rows.push_back(mk(0, 0, 0, 16384, 1, typed(0, 0, q, 0)));
		table_rows.push_back(mk(16384, 0, 16384, 0, 1, typed(q, p, q, 1)));
		table_rows.push_back(mk(16384, 0, -16384, 0, 1, typed(q, -p, q, 1)));
		table_rows.push_back(mk(11585, 0, 11585, 0));
		table_rows.push_back(mk(11585, 0, -11585, 0));
		table_rows.push_back(mk(16384, 16384, 16384, 16384));
		table_rows.push_back(mk(-16384, -16384, -16384, -16384));
		table_rows.push_back(mk(-32768, -32768, -32768, -32768));
		table_rows.push_back(mk(32767, 32767, 32767, 32767));
		table_rows.push_back(mk(32767, -32768, 32767, -32768));
		table_rows.push_back(mk(0, 0, 16384, 0));
		table_rows.push_back(mk(11585, 11585, 0, 0));
		table_rows.push_back(mk(11585, -11585, 0, 0));
		table_rows.push_back(mk(11585, 0, 0, -11585));
		table_rows.push_back(mk(8192, 8192, 8192, 8192));
		table_rows.push_back(mk(1, 0, 0, 0));
		table_rows.push_back(mk(0, 1, -1, 1));
		table_rows.push_back(mk(16384, 0, 11, 0));
		table_rows.push_back(mk(-1, 21845, -21846, 5461));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_quat(table_rows[i].w, table_rows[i].x, table_rows[i].y, table_rows[i].z,
				table_rows[i].known, table_rows[i].res);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 3) begin
				send_idle_pct = 73;
				recv_idle_pct = 36;
			end
			if (k == 2 * N_RANDOM / 3) begin
				// sender pause until the block is empty, then a long receiver hold
				quat.valid <= 1'b0;
				@(posedge clk);
				drain_wait();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				fork
					hold_receiver(300);
				join_none
			end
			send_random();
		end
		quat.valid <= 1'b0;

		drain_wait();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && angles_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_quat_if.sv
hw/rtl/q2e_euler_if.sv
hw/rtl/q2e_front.sv
hw/rtl/q2e_fifo.sv
hw/rtl/q2e_isqrt.sv
hw/rtl/q2e_cordic.sv
hw/rtl/q2e_back.sv
hw/rtl/quaternion_to_euler_angles.sv
verif/tb_q2e_channels.sv
verif/tb_quaternion_to_euler_angles.sv
